/* src/ppfp_pkg.sv */
// ----------------------------------------------------------------------------
// ppfp_pkg
// Types and constants shared by the packed parameter file parser modules.
// ----------------------------------------------------------------------------
package ppfp_pkg;

	localparam int NAME_CHARS = 16;

	localparam logic [15:0] MAGIC_PLAIN    = 16'h671B;
	localparam logic [15:0] MAGIC_DEFAULTS = 16'h671C;

	typedef enum logic [1:0] {
		KIND_CHAR   = 2'd0,
		KIND_VALUE  = 2'd1,
		KIND_ACCEPT = 2'd2,
		KIND_REJECT = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_HEADER_SHORT = 3'd0,
		ERR_MAGIC        = 3'd1,
		ERR_COUNT        = 3'd2,
		ERR_NAME_LONG    = 3'd3,
		ERR_EOF_RECORD   = 3'd4,
		ERR_TYPE         = 3'd5,
		ERR_TOO_MANY     = 3'd6,
		ERR_TOO_FEW      = 3'd7
	} err_t;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_PAD     = 3'd1,
		PH_LEN     = 3'd2,
		PH_NAME    = 3'd3,
		PH_VALUE   = 3'd4,
		PH_DEFAULT = 3'd5,
		PH_ERROR   = 3'd6
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  name_char;
		logic [31:0] value_bits;
		logic [31:0] default_bits;
		logic [1:0]  value_type;
		logic        has_default;
		logic [2:0]  error_code;
		logic [15:0] records_seen;
		logic        last;
	} out_beat_t;

	// controller to datapath
	typedef struct packed {
		logic       load;      // latch input beat into datapath
		logic       clear;     // reset datapath state
		logic       emit_char; // load output with name char at emit index
		logic       emit_val;  // load output with value record
		logic       emit_end;  // load output with eof verdict
		logic [4:0] emit_idx;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       record_done; // record completed and counted
		logic [4:0] name_end;
	} dp_stat_t;

endpackage

/* src/ppfp_if.sv */
// ----------------------------------------------------------------------------
// ppfp_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface ppfp_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* src/ppfp_datapath.sv */
// ----------------------------------------------------------------------------
// ppfp_datapath
// Parse state, name store and result formatting for one input beat a step.
// ----------------------------------------------------------------------------
module ppfp_datapath
	import ppfp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_beat_t  in_beat,
	input  ctl_cmd_t  cmd,
	output dp_stat_t  stat,
	output out_beat_t res
);

	localparam int IW = $clog2(NAME_CHARS);

	phase_t      phase_q;
	err_t        err_q;
	logic [2:0]  bidx_q;
	logic [47:0] hdr_q;
	logic        dfl_file_q;
	logic [15:0] total_q;
	logic [15:0] count_q;
	logic [3:0]  rtype_q;
	logic        wants_q;
	logic [4:0]  prefix_q;
	logic [4:0]  nlen_q;
	logic [7:0]  names_q [NAME_CHARS];
	logic [31:0] val_q;
	logic [31:0] dfl_q;
	logic        done_q;

	logic [7:0]  b;
	logic [2:0]  tsize;
	logic        hd;
	logic [4:0]  nl;
	logic [5:0]  nsum;
	logic [47:0] hdr_n;
	out_beat_t   res_n;

	function automatic logic [31:0] ext(input logic [31:0] v, input logic [3:0] t);
		logic [31:0] r;
		r = v;
		if (t == 4'd1)
			r = {{24{v[7]}}, v[7:0]};
		else if (t == 4'd2)
			r = {{16{v[15]}}, v[15:0]};
		return r;
	endfunction

	assign b     = in_beat.data_byte;
	assign tsize = (rtype_q == 4'd1) ? 3'd1 : ((rtype_q == 4'd2) ? 3'd2 : 3'd4);
	assign hd    = wants_q & dfl_file_q;
	assign nl    = {1'b0, b[7:4]} + 5'd1;
	assign nsum  = {1'b0, nl} + {2'b0, b[3:0]};
	always_comb begin
		hdr_n = hdr_q;
		hdr_n[8*bidx_q +: 8] = b;
	end

	assign stat.record_done = done_q;
	assign stat.name_end    = nlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			err_q <= ERR_HEADER_SHORT;
			bidx_q <= '0;
			hdr_q <= '0;
			dfl_file_q <= 1'b0;
			total_q <= '0;
			count_q <= '0;
			rtype_q <= '0;
			wants_q <= 1'b0;
			prefix_q <= '0;
			nlen_q <= '0;
			val_q <= '0;
			dfl_q <= '0;
			done_q <= 1'b0;
			for (int i = 0; i < NAME_CHARS; i++) names_q[i] <= '0;
		end else if (cmd.clear) begin
			phase_q <= PH_HEADER;
			err_q <= ERR_HEADER_SHORT;
			bidx_q <= '0;
			hdr_q <= '0;
			dfl_file_q <= 1'b0;
			total_q <= '0;
			count_q <= '0;
			rtype_q <= '0;
			wants_q <= 1'b0;
			prefix_q <= '0;
			nlen_q <= '0;
			val_q <= '0;
			dfl_q <= '0;
			done_q <= 1'b0;
			for (int i = 0; i < NAME_CHARS; i++) names_q[i] <= '0;
		end else if (cmd.load) begin
			done_q <= 1'b0;
			case (phase_q)
				PH_HEADER: begin
					hdr_q <= hdr_n;
					if (bidx_q == 3'd5) begin
						bidx_q <= '0;
						if (hdr_n[15:0] != MAGIC_PLAIN && hdr_n[15:0] != MAGIC_DEFAULTS) begin
							phase_q <= PH_ERROR;
							err_q <= ERR_MAGIC;
						end else if (hdr_n[31:16] != hdr_n[47:32]) begin
							phase_q <= PH_ERROR;
							err_q <= ERR_COUNT;
						end else begin
							dfl_file_q <= (hdr_n[15:0] == MAGIC_DEFAULTS);
							total_q <= hdr_n[31:16];
							phase_q <= PH_PAD;
						end
					end else begin
						bidx_q <= bidx_q + 3'd1;
					end
				end
				PH_PAD: begin
					if (b != 8'd0) begin
						rtype_q <= b[3:0];
						wants_q <= b[4];
						phase_q <= PH_LEN;
					end
				end
				PH_LEN: begin
					if (nsum > 6'(NAME_CHARS)) begin
						phase_q <= PH_ERROR;
						err_q <= ERR_NAME_LONG;
					end else begin
						prefix_q <= {1'b0, b[3:0]};
						nlen_q <= nsum[4:0];
						phase_q <= PH_NAME;
					end
				end
				PH_NAME: begin
					names_q[prefix_q[IW-1:0]] <= b;
					if (prefix_q + 5'd1 < nlen_q) begin
						prefix_q <= prefix_q + 5'd1;
					end else begin
						if (nlen_q < 5'(NAME_CHARS)) names_q[nlen_q[IW-1:0]] <= 8'd0;
						if (rtype_q < 4'd1 || rtype_q > 4'd4) begin
							phase_q <= PH_ERROR;
							err_q <= ERR_TYPE;
						end else begin
							val_q <= '0;
							dfl_q <= '0;
							bidx_q <= '0;
							phase_q <= PH_VALUE;
						end
					end
				end
				PH_VALUE, PH_DEFAULT: begin
					if (phase_q == PH_VALUE)
						val_q[8*bidx_q[1:0] +: 8] <= b;
					else
						dfl_q[8*bidx_q[1:0] +: 8] <= b;
					if (bidx_q + 3'd1 < tsize) begin
						bidx_q <= bidx_q + 3'd1;
					end else begin
						bidx_q <= '0;
						if (phase_q == PH_VALUE && hd) begin
							phase_q <= PH_DEFAULT;
						end else if (count_q >= total_q) begin
							phase_q <= PH_ERROR;
							err_q <= ERR_TOO_MANY;
						end else begin
							count_q <= count_q + 16'd1;
							done_q <= 1'b1;
							phase_q <= PH_PAD;
						end
					end
				end
				default: ;
			endcase
		end else if (cmd.emit_val) begin
			done_q <= 1'b0;
		end
	end

	always_comb begin
		res_n = '0;
		res_n.records_seen = count_q;
		if (cmd.emit_char) begin
			res_n.kind = KIND_CHAR;
			res_n.name_char = names_q[cmd.emit_idx[IW-1:0]];
		end else if (cmd.emit_val) begin
			res_n.kind = KIND_VALUE;
			res_n.value_bits = ext(val_q, rtype_q);
			res_n.default_bits = hd ? ext(dfl_q, rtype_q) : 32'd0;
			res_n.value_type = 2'(rtype_q - 4'd1);
			res_n.has_default = hd;
			res_n.last = 1'b1;
		end else begin
			res_n.last = 1'b1;
			res_n.kind = KIND_REJECT;
			case (phase_q)
				PH_ERROR:  res_n.error_code = err_q;
				PH_HEADER: res_n.error_code = ERR_HEADER_SHORT;
				PH_PAD: begin
					if (count_q == total_q) res_n.kind = KIND_ACCEPT;
					else res_n.error_code = ERR_TOO_FEW;
				end
				default:   res_n.error_code = ERR_EOF_RECORD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_char || cmd.emit_val || cmd.emit_end) res <= res_n;
	end

endmodule

/* src/ppfp_ctrl.sv */
// ----------------------------------------------------------------------------
// ppfp_ctrl
// Handshake sequencer: takes a beat and, when it completes a record, plays out name and value results.
// ----------------------------------------------------------------------------
module ppfp_ctrl
	import ppfp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_eof,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_TAKE,
		S_CHECK,
		S_NAME,
		S_VALUE
	} state_t;

	state_t     state_q;
	logic       ov_q;
	logic [4:0] idx_q;
	logic       free;

	assign free      = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign in_ready  = (state_q == S_TAKE) && free;

	always_comb begin
		cmd = '0;
		cmd.emit_idx = idx_q;
		case (state_q)
			S_TAKE: begin
				if (in_valid && free) begin
					cmd.load = !in_eof;
					cmd.emit_end = in_eof;
					cmd.clear = in_eof;
				end
			end
			S_NAME:  cmd.emit_char = free && (idx_q < stat.name_end) &&
				(idx_q < 5'(NAME_CHARS));
			S_VALUE: cmd.emit_val = free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_TAKE;
			ov_q <= 1'b0;
			idx_q <= '0;
		end else begin
			ov_q <= cmd.emit_char || cmd.emit_val || cmd.emit_end || (ov_q && !out_ready);
			case (state_q)
				S_TAKE: begin
					if (in_valid && free && !in_eof) state_q <= S_CHECK;
				end
				S_CHECK: begin
					idx_q <= '0;
					state_q <= stat.record_done ? S_NAME : S_TAKE;
				end
				S_NAME: begin
					if (free) begin
						if (idx_q < stat.name_end && idx_q < 5'(NAME_CHARS)) begin
							idx_q <= idx_q + 5'd1;
						end else begin
							state_q <= S_VALUE;
						end
					end
				end
				S_VALUE: begin
					if (free) state_q <= S_TAKE;
				end
				default: state_q <= S_TAKE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) in_ready |-> state_q == S_TAKE)
		else $error("ready outside take state");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.load |=> state_q == S_CHECK)
		else $error("load not followed by check");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit_val |=> ov_q)
		else $error("value emit lost");

endmodule

/* src/packed_parameter_file_parser.sv */
// ----------------------------------------------------------------------------
// packed_parameter_file_parser
// Byte-serial packed parameter file parser with per-record result runs.
// ----------------------------------------------------------------------------
// a data beat passes the take (load) state, then the record check state; eof loads its verdict directly
// a record end plays out one result per name character in the name state, then the value beat
// results leave through a one-beat output register, stalled by out.ready
// arst_n clears the controller and all parse state including the name store
// ----------------------------------------------------------------------------
module packed_parameter_file_parser
	import ppfp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	ppfp_if.sink   in_ch,
	ppfp_if.source out_ch
);

	ctl_cmd_t  cmd;
	dp_stat_t  stat;
	in_beat_t  ib;
	out_beat_t res;

	assign ib = in_ch.payload;
	assign out_ch.payload = res;

	ppfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_eof    (ib.end_of_file),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ppfp_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_beat (ib),
		.cmd     (cmd),
		.stat    (stat),
		.res     (res)
	);

endmodule
